// ----- hdl/m64h_pkg.sv -----
// Shared types and constants for the MurmurHash64A block.
package m64h_pkg;

  localparam logic [63:0] MUR_M      = 64'hc6a4a7935bd1e995;
  localparam int unsigned MUR_R      = 47;
  localparam logic [63:0] SEED_RESET = 64'hdeadbeefdeadbeef;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned WORD_W     = 64;

  // Multiplier operand source
  typedef enum logic [1:0] {
    SEL_LEN,
    SEL_K,
    SEL_H
  } mul_sel_e;

  // Datapath register updates
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,    // latch word, last flag and (optionally) length
    OP_H_SEED,  // h = seed ^ p
    OP_K_SHX,   // k = p ^ (p >> R)
    OP_H_XP,    // h = h ^ p
    OP_H_P,     // h = p
    OP_H_FIN,   // h = p ^ (p >> R)
    OP_H_TAIL,  // h = h ^ (k & tail mask)
    OP_H_SHX,   // h = h ^ (h >> R)
    OP_OUT      // load output register with h
  } dp_op_e;

  typedef struct packed {
    dp_op_e   op;
    logic     load_len;
    logic     mul_start;
    mul_sel_e mul_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic tail_nz;
    logic len_nz;
    logic mul_done;
    logic out_busy;
  } dp_sts_t;

endpackage

// ----- hdl/m64h_mul.sv -----
// Iterative 64-bit by constant multiplier, low 64 bits, one 32x32 product per cycle.
module m64h_mul import m64h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] oper_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  localparam logic [1:0] PH_LL = 2'd0;  // lo(a) * lo(M), full width
  localparam logic [1:0] PH_HL = 2'd1;  // hi(a) * lo(M), low half into upper word
  localparam logic [1:0] PH_LH = 2'd2;  // lo(a) * hi(M), low half into upper word

  logic [63:0] a_q;
  logic [63:0] p_q, p_d;
  logic [1:0]  ph_q;
  logic        run_q, done_q;
  logic [31:0] x, y;
  logic [63:0] pp;

  assign x  = (ph_q == PH_HL) ? a_q[63:32] : a_q[31:0];
  assign y  = (ph_q == PH_LH) ? MUR_M[63:32] : MUR_M[31:0];
  assign pp = {32'd0, x} * {32'd0, y};

  always_comb begin
    if (ph_q == PH_LL) begin
      p_d = pp;
    end else begin
      p_d = {p_q[63:32] + pp[31:0], p_q[31:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= PH_LL;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        ph_q  <= PH_LL;
      end else if (run_q) begin
        if (ph_q == PH_LH) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          ph_q <= ph_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= oper_i;
    end
    if (run_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

// ----- hdl/m64h_dp.sv -----
// Datapath: hash, word and length registers, seed register, multiplier, output register.
module m64h_dp import m64h_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [WORD_W-1:0] word_i,
  input  logic [LEN_W-1:0]  len_i,
  input  logic              last_i,
  input  logic              cfg_we_i,
  input  logic [63:0]       cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       out_hash_o
);

  logic [63:0]      seed_q;
  logic [63:0]      h_q, h_d;
  logic [63:0]      k_q, k_d;
  logic [LEN_W-1:0] len_q;
  logic             last_q;
  logic             out_valid_q;
  logic [63:0]      out_hash_q;
  logic [63:0]      mul_oper;
  logic [63:0]      p;
  logic             mul_done;
  logic [63:0]      tail_mask;

  always_comb begin
    case (cmd_i.mul_sel)
      SEL_LEN: mul_oper = {{(64 - LEN_W){1'b0}}, len_q};
      SEL_K:   mul_oper = k_q;
      SEL_H:   mul_oper = h_q;
      default: mul_oper = h_q;
    endcase
  end

  m64h_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .oper_i  (mul_oper),
    .done_o  (mul_done),
    .prod_o  (p)
  );

  // byte b kept when b < length mod 8
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      tail_mask[8*b +: 8] = ({1'b0, len_q[2:0]} > 4'(b)) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    h_d = h_q;
    k_d = k_q;
    case (cmd_i.op)
      OP_LOAD:   k_d = word_i;
      OP_H_SEED: h_d = seed_q ^ p;
      OP_K_SHX:  k_d = p ^ (p >> MUR_R);
      OP_H_XP:   h_d = h_q ^ p;
      OP_H_P:    h_d = p;
      OP_H_FIN:  h_d = p ^ (p >> MUR_R);
      OP_H_TAIL: h_d = h_q ^ (k_q & tail_mask);
      OP_H_SHX:  h_d = h_q ^ (h_q >> MUR_R);
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SEED_RESET;
      h_q         <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_data_i;
      end
      h_q <= h_d;
      if (cmd_i.op == OP_LOAD && cmd_i.load_len) begin
        len_q <= len_i;
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    if (cmd_i.op == OP_LOAD) begin
      last_q <= last_i;
    end
    if (cmd_i.op == OP_OUT) begin
      out_hash_q <= h_q;
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.tail_nz  = (len_q[2:0] != 3'd0);
  assign sts_o.len_nz   = (len_q != '0);
  assign sts_o.mul_done = mul_done;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_hash_o  = out_hash_q;

endmodule

// ----- hdl/m64h_ctrl.sv -----
// Controller: sequences seeding, word mixing, tail handling and finalization.
module m64h_ctrl import m64h_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_W_SEED,
    S_BRANCH,
    S_W_K1,
    S_K2,
    S_W_K2,
    S_HMUL,
    S_W_HMIX,
    S_FIN,
    S_FMUL,
    S_W_FIN,
    S_OUT
  } state_e;

  state_e state_q;
  logic   in_msg_q;
  logic   full_mix;

  assign in_ready_o = (state_q == S_IDLE);
  assign full_mix   = !sts_i.last || (!sts_i.tail_nz && sts_i.len_nz);

  always_comb begin
    cmd_o.op        = OP_NONE;
    cmd_o.load_len  = !in_msg_q;
    cmd_o.mul_start = 1'b0;
    cmd_o.mul_sel   = SEL_H;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
        end
      end
      S_START: begin
        if (!in_msg_q) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = SEL_LEN;
        end
      end
      S_W_SEED: if (sts_i.mul_done) cmd_o.op = OP_H_SEED;
      S_BRANCH: begin
        if (full_mix) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = SEL_K;
        end else if (sts_i.tail_nz) begin
          cmd_o.op = OP_H_TAIL;
        end
      end
      S_W_K1: if (sts_i.mul_done) cmd_o.op = OP_K_SHX;
      S_K2: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = SEL_K;
      end
      S_W_K2: if (sts_i.mul_done) cmd_o.op = OP_H_XP;
      S_HMUL: cmd_o.mul_start = 1'b1;
      S_W_HMIX: if (sts_i.mul_done) cmd_o.op = OP_H_P;
      S_FIN: cmd_o.op = OP_H_SHX;
      S_FMUL: cmd_o.mul_start = 1'b1;
      S_W_FIN: if (sts_i.mul_done) cmd_o.op = OP_H_FIN;
      S_OUT: if (!sts_i.out_busy) cmd_o.op = OP_OUT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      in_msg_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_START;
        S_START:  state_q <= in_msg_q ? S_BRANCH : S_W_SEED;
        S_W_SEED: if (sts_i.mul_done) state_q <= S_BRANCH;
        S_BRANCH: begin
          if (full_mix) begin
            state_q <= S_W_K1;
          end else if (sts_i.tail_nz) begin
            state_q <= S_HMUL;
          end else begin
            state_q <= S_FIN;  // empty message: word adds nothing
          end
        end
        S_W_K1:   if (sts_i.mul_done) state_q <= S_K2;
        S_K2:     state_q <= S_W_K2;
        S_W_K2:   if (sts_i.mul_done) state_q <= S_HMUL;
        S_HMUL:   state_q <= S_W_HMIX;
        S_W_HMIX: begin
          if (sts_i.mul_done) begin
            if (sts_i.last) begin
              state_q <= S_FIN;
            end else begin
              in_msg_q <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end
        S_FIN:    state_q <= S_FMUL;
        S_FMUL:   state_q <= S_W_FIN;
        S_W_FIN:  if (sts_i.mul_done) state_q <= S_OUT;
        S_OUT: begin
          if (!sts_i.out_busy) begin
            in_msg_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/murmur64a_hash.sv -----
// MurmurHash64A streaming hash core, top level.
// One word in flight at a time; every multiply by M runs on one shared 32x32
// multiplier in three passes, from issue to write-back.
// Inner word: ready again once its mix is written back; the first word also waits for the seed multiply.
// The last word adds finalization; a tail or empty word skips the word mix.
// The hash is held in an output register, so a new word is taken while it waits.
// Reset (async, active low) clears control state, seed returns to its reset value.
module murmur64a_hash import m64h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // data_word[63:0], msg_length[94:64], zero pad
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // hash[63:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i      // seed
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  m64h_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  m64h_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .word_i      (s_axis_tdata[63:0]),
    .len_i       (s_axis_tdata[94:64]),
    .last_i      (s_axis_tlast),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hash_o  (m_axis_tdata)
  );

endmodule

// ----- hdl/m64h_chk.sv -----
// Port-level checker for the hash core, bound to the top level.
module m64h_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // one word at a time: ready drops right after a transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready held after transaction");

  // a result never appears in the cycle right after an input transaction
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result raised too early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

endmodule

bind murmur64a_hash m64h_chk u_m64h_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
